// ----- hw/rtl/ihex_pkg.sv -----
// Package for the Intel HEX word loader: record phase codes, character
// constants, the result word type and the hex digit decode.
// No dependencies; imported by every other file of the block.
package ihex_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned DataW  = 32;

  localparam logic [CharW-1:0] ColonCode = 8'd58;  // ':'
  localparam logic [CharW-1:0] ZeroCode  = 8'd48;  // '0'
  localparam logic [CharW-1:0] AlphaGap  = 8'd7;   // 'A' - '9' - 1

  localparam logic [7:0] KindData   = 8'h00;
  localparam logic [7:0] KindExtLin = 8'h04;

  typedef enum logic [2:0] {
    PhHunt = 3'd0,
    PhLen  = 3'd1,
    PhOfs  = 3'd2,
    PhType = 3'd3,
    PhExt  = 3'd4,
    PhData = 3'd5
  } phase_e;

  typedef struct packed {
    logic             emit;
    logic [AddrW-1:0] word_address;
    logic [DataW-1:0] word_data;
  } word_t;

  // Character to nibble: code - '0', less seven more above nine, low 4 bits.
  function automatic logic [3:0] hex_digit(input logic [CharW-1:0] code);
    logic [CharW-1:0] v;
    v = code - ZeroCode;
    if (v > 8'd9) begin
      v = v - AlphaGap;
    end
    return v[3:0];
  endfunction

endpackage

// ----- hw/rtl/ihex_char_if.sv -----
// Character channel: valid/ready handshake carrying one text character.
// Depends on ihex_pkg for the character width.
interface ihex_char_if;
  import ihex_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// ----- hw/rtl/ihex_word_if.sv -----
// Word channel: valid/ready handshake carrying an address and a 32-bit word.
// Depends on ihex_pkg for the address and data widths.
interface ihex_word_if;
  import ihex_pkg::*;

  logic             valid;
  logic             ready;
  logic [AddrW-1:0] word_address;
  logic [DataW-1:0] word_data;

  modport source (output valid, output word_address, output word_data, input ready);
  modport sink   (input valid, input word_address, input word_data, output ready);
endinterface

// ----- hw/rtl/ihex_in_reg.sv -----
// Input register of the loader: holds one character until the decoder takes it.
// Depends on ihex_pkg.
module ihex_in_reg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic                    take_i,
  input  logic [ihex_pkg::CharW-1:0] char_i,
  output logic                    valid_o,
  output logic [ihex_pkg::CharW-1:0] char_o
);
  import ihex_pkg::*;

  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      char_q <= char_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
endmodule

// ----- hw/rtl/ihex_decoder.sv -----
// Record decoder: phase machine and field registers, one character per step.
// Depends on ihex_pkg for phase codes, hex_digit and the word_t result.
module ihex_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [ihex_pkg::CharW-1:0] char_i,
  output ihex_pkg::word_t            word_o
);
  import ihex_pkg::*;

  phase_e           phase_q, phase_d;
  logic [2:0]       nib_cnt_q, nib_cnt_d;
  logic [7:0]       rec_len_q, rec_len_d;
  logic [15:0]      field_q, field_d;
  logic [7:0]       kind_q, kind_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [DataW-1:0] word_q, word_d;
  logic [5:0]       words_left_q, words_left_d;

  logic [3:0]       dig;
  logic [2:0]       nib_inc;
  logic [2:0]       nib_pos;
  logic [DataW-1:0] word_or;

  assign dig     = hex_digit(char_i);
  assign nib_inc = nib_cnt_q + 3'd1;
  // High digit of each byte lands in the upper nibble of that byte.
  assign nib_pos = {nib_cnt_q[2:1], ~nib_cnt_q[0]};
  assign word_or = word_q | (DataW'(dig) << {nib_pos, 2'b00});

  always_comb begin
    phase_d      = phase_q;
    nib_cnt_d    = nib_cnt_q;
    rec_len_d    = rec_len_q;
    field_d      = field_q;
    kind_d       = kind_q;
    addr_d       = addr_q;
    word_d       = word_q;
    words_left_d = words_left_q;
    word_o       = '{emit: 1'b0, word_address: addr_q, word_data: word_or};

    unique case (phase_q)
      PhLen: begin
        rec_len_d = {rec_len_q[3:0], dig};
        nib_cnt_d = nib_inc;
        if (nib_inc == 3'd2) begin
          nib_cnt_d = '0;
          field_d   = '0;
          phase_d   = PhOfs;
        end
      end
      PhOfs: begin
        field_d   = {field_q[11:0], dig};
        nib_cnt_d = nib_inc;
        if (nib_inc == 3'd4) begin
          nib_cnt_d = '0;
          kind_d    = '0;
          phase_d   = PhType;
        end
      end
      PhType: begin
        kind_d    = {kind_q[3:0], dig};
        nib_cnt_d = nib_inc;
        if (nib_inc == 3'd2) begin
          nib_cnt_d = '0;
          if (kind_d == KindData) begin
            addr_d       = {addr_q[AddrW-1:16], field_q};
            words_left_d = rec_len_q[7:2];
            word_d       = '0;
            phase_d      = (rec_len_q[7:2] != 6'd0) ? PhData : PhHunt;
          end else if (kind_d == KindExtLin) begin
            field_d = '0;
            phase_d = PhExt;
          end else begin
            phase_d = PhHunt;
          end
        end
      end
      PhExt: begin
        field_d   = {field_q[11:0], dig};
        nib_cnt_d = nib_inc;
        if (nib_inc == 3'd4) begin
          nib_cnt_d = '0;
          addr_d    = {field_d, addr_q[15:0]};
          phase_d   = PhHunt;
        end
      end
      PhData: begin
        word_d = word_or;
        if (nib_cnt_q == 3'd7) begin
          word_o.emit  = 1'b1;
          addr_d       = addr_q + AddrW'(4);
          word_d       = '0;
          nib_cnt_d    = '0;
          words_left_d = words_left_q - 6'd1;
          if (words_left_d == 6'd0) begin
            phase_d = PhHunt;
          end
        end else begin
          nib_cnt_d = nib_inc;
        end
      end
      default: begin
        if (char_i == ColonCode) begin
          phase_d   = PhLen;
          nib_cnt_d = '0;
          rec_len_d = '0;
        end else begin
          phase_d = PhHunt;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHunt;
      nib_cnt_q    <= '0;
      rec_len_q    <= '0;
      field_q      <= '0;
      kind_q       <= '0;
      addr_q       <= '0;
      word_q       <= '0;
      words_left_q <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      nib_cnt_q    <= nib_cnt_d;
      rec_len_q    <= rec_len_d;
      field_q      <= field_d;
      kind_q       <= kind_d;
      addr_q       <= addr_d;
      word_q       <= word_d;
      words_left_q <= words_left_d;
    end
  end
endmodule

// ----- hw/rtl/ihex_out_reg.sv -----
// Result register of the loader: holds one decoded word until the sink takes it.
// Depends on ihex_pkg for word_t.
module ihex_out_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  ihex_pkg::word_t            word_i,
  input  logic                       ready_i,
  output logic                       valid_o,
  output logic [ihex_pkg::AddrW-1:0] word_address_o,
  output logic [ihex_pkg::DataW-1:0] word_data_o
);
  import ihex_pkg::*;

  logic             valid_q, valid_d;
  logic [AddrW-1:0] addr_q;
  logic [DataW-1:0] data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = word_i.emit;
    end else if (valid_q && ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && word_i.emit) begin
      addr_q <= word_i.word_address;
      data_q <= word_i.word_data;
    end
  end

  assign valid_o        = valid_q;
  assign word_address_o = addr_q;
  assign word_data_o    = data_q;
endmodule

// ----- hw/rtl/intel_hex_word_loader.sv -----
// Intel HEX word loader: top level joining input register, decoder and
// result register. Depends on ihex_pkg, ihex_char_if, ihex_word_if.
//
// Usage:
//   char_i carries the HEX text, one ASCII character per word on the channel.
//   Characters before a colon are dropped; after it the length, offset and
//   type pairs are read. A data record yields one word_o word for every eight
//   data digits, with word_address the running byte address (upper half kept
//   across records, wrapping at 2^32) and word_data the four bytes taken
//   little-endian. An extended linear address record loads the upper address
//   half. Checksums and trailing bytes are skipped, never checked.
//   Path: a character waits in the input register until the decoder advances
//   on it; that step also loads its word into the result register.
//   Throughput: one character per cycle while word_o is not stalled, set by
//   the single decode step between the input register and the result register.
//   Reset (rst_ni low, asynchronous): both channels go empty and the decoder
//   hunts for a colon with the address at zero.
//   Stall: while a word waits on word_o the decoder holds; at most one more
//   character is taken into the input register, then char_i.ready stays low
//   until the word is taken.
module intel_hex_word_loader (
  input  logic        clk_i,
  input  logic        rst_ni,
  ihex_char_if.sink   char_i,
  ihex_word_if.source word_o
);
  import ihex_pkg::*;

  logic             in_valid;
  logic [CharW-1:0] in_char;
  logic             advance;
  logic             in_load;
  word_t            dec_word;

  // Advance the decoder when a character waits and the result slot is free
  // or being emptied this cycle.
  assign advance      = in_valid && (!word_o.valid || word_o.ready);
  assign char_i.ready = !in_valid || advance;
  assign in_load      = char_i.valid && char_i.ready;

  ihex_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_load),
    .take_i  (advance),
    .char_i  (char_i.char_code),
    .valid_o (in_valid),
    .char_o  (in_char)
  );

  ihex_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .char_i (in_char),
    .word_o (dec_word)
  );

  ihex_out_reg u_out_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (advance),
    .word_i         (dec_word),
    .ready_i        (word_o.ready),
    .valid_o        (word_o.valid),
    .word_address_o (word_o.word_address),
    .word_data_o    (word_o.word_data)
  );
endmodule

// ----- sim/tb_intel_hex_word_loader.sv -----
// Self-checking testbench for intel_hex_word_loader: streams HEX text into the
// character channel and checks every word on the word channel.
// Depends on ihex_pkg, ihex_char_if, ihex_word_if and the loader RTL.
module tb_intel_hex_word_loader;
  timeunit 1ns;
  timeprecision 1ps;

  import ihex_pkg::*;

  localparam int ClkPeriod   = 20;
  localparam int TextTarget  = 950;   // characters of random text to send
  localparam int HoldCycles  = 300;   // one long stall on the word side
  localparam int IdleLimit   = 2000;  // cycles with nothing moving on either channel
  localparam int DrainCycles = 12;    // look for stray words after the last one
  localparam int ReportLimit = 10;

  // One decoded word as it should leave the block.
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } stored_word_t;

  // A row of the directed text; the word is typed in only where obvious.
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             typed;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } text_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ihex_char_if char_bus ();
  ihex_word_if word_bus ();

  intel_hex_word_loader dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .char_i (char_bus),
    .word_o (word_bus)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder model: a shadow of the record parser, advanced once per character
  // the block takes in.
  // ---------------------------------------------------------------------------
  phase_e          rec_phase;
  logic [2:0]      digit_cnt;
  logic [7:0]      rec_len;
  logic [15:0]     field_sr;     // offset, then extended upper half
  logic [7:0]      rec_kind;
  logic [AddrW-1:0] load_addr;   // running byte address; upper half kept
  logic [DataW-1:0] word_sr;
  logic [5:0]      words_rem;

  stored_word_t    pending_words [$];
  logic [CharW-1:0] text_q [$];

  int  mismatches   = 0;
  int  burst_left   = 0;
  int  random_chars = 0;
  int  idle_cycles  = 0;
  bit  max_len_done = 1'b0;
  bit  hold_wanted  = 1'b0;

  function automatic void clear_decoder();
    rec_phase = PhHunt;
    digit_cnt = '0;
    rec_len   = '0;
    field_sr  = '0;
    rec_kind  = '0;
    load_addr = '0;
    word_sr   = '0;
    words_rem = '0;
  endfunction

  // Any character counts as a digit inside a record: subtract '0', take a
  // further seven off anything past nine (codes below '0' wrap round first).
  function automatic logic [3:0] char_nibble(input logic [CharW-1:0] c);
    logic [7:0] v;
    v = c - 8'd48;
    if (v > 8'd9) v = v - 8'd7;
    return v[3:0];
  endfunction

  // Advance the model by one character; return 1 with the word if one is due.
  function automatic bit decode_char(input logic [CharW-1:0] c, output stored_word_t w);
    logic [3:0] d;
    logic [4:0] sh;
    d = char_nibble(c);
    w = '0;
    case (rec_phase)
      PhLen: begin
        rec_len   = {rec_len[3:0], d};
        digit_cnt = digit_cnt + 3'd1;
        if (digit_cnt == 3'd2) begin
          digit_cnt = '0;
          field_sr  = '0;
          rec_phase = PhOfs;
        end
      end
      PhOfs: begin
        field_sr  = {field_sr[11:0], d};
        digit_cnt = digit_cnt + 3'd1;
        if (digit_cnt == 3'd4) begin
          digit_cnt = '0;
          rec_kind  = '0;
          rec_phase = PhType;
        end
      end
      PhType: begin
        rec_kind  = {rec_kind[3:0], d};
        digit_cnt = digit_cnt + 3'd1;
        if (digit_cnt == 3'd2) begin
          digit_cnt = '0;
          if (rec_kind == KindData) begin
            // Low half from the offset, upper half kept from before.
            load_addr = {load_addr[31:16], field_sr};
            words_rem = rec_len[7:2];
            word_sr   = '0;
            rec_phase = (words_rem != '0) ? PhData : PhHunt;
          end else if (rec_kind == KindExtLin) begin
            field_sr  = '0;
            rec_phase = PhExt;
          end else begin
            rec_phase = PhHunt;
          end
        end
      end
      PhExt: begin
        field_sr  = {field_sr[11:0], d};
        digit_cnt = digit_cnt + 3'd1;
        if (digit_cnt == 3'd4) begin
          digit_cnt = '0;
          load_addr = {field_sr, load_addr[15:0]};
          rec_phase = PhHunt;
        end
      end
      PhData: begin
        // High digit of each byte first, bytes placed little-endian.
        sh      = 5'({digit_cnt[2:1], 3'b000} + (digit_cnt[0] ? 0 : 4));
        word_sr = word_sr | (DataW'(d) << sh);
        if (digit_cnt == 3'd7) begin
          w.addr    = load_addr;
          w.data    = word_sr;
          load_addr = load_addr + 32'd4;
          word_sr   = '0;
          digit_cnt = '0;
          words_rem = words_rem - 6'd1;
          if (words_rem == '0) rec_phase = PhHunt;
          return 1'b1;
        end
        digit_cnt = digit_cnt + 3'd1;
      end
      default: begin
        if (c == ColonCode) begin
          rec_phase = PhLen;
          digit_cnt = '0;
          rec_len   = '0;
        end else begin
          rec_phase = PhHunt;
        end
      end
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Text generation: well-formed records with random content, plus noise and
  // records cut short.
  // ---------------------------------------------------------------------------
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return ZeroCode + CharW'(n);
    return ($urandom_range(0, 1) ? "A" : "a") + CharW'(n) - 8'd10;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    text_q.push_back(hex_char(b[7:4]));
    text_q.push_back(hex_char(b[3:0]));
  endfunction

  function automatic void push_header(input logic [7:0] len, input logic [15:0] ofs,
                                      input logic [7:0] kind);
    text_q.push_back(ColonCode);
    push_byte(len);
    push_byte(ofs[15:8]);
    push_byte(ofs[7:0]);
    push_byte(kind);
  endfunction

  // Data bytes: mostly clean hex in either case, now and then any code at all.
  function automatic void push_payload(input int n_bytes);
    for (int i = 0; i < 2 * n_bytes; i++) begin
      if ($urandom_range(0, 19) == 0) text_q.push_back(CharW'($urandom_range(0, 255)));
      else text_q.push_back(hex_char(4'($urandom_range(0, 15))));
    end
  endfunction

  function automatic void push_tail();
    push_byte(8'($urandom_range(0, 255)));  // checksum, never checked
    if ($urandom_range(0, 1)) begin
      text_q.push_back(8'h0D);
      text_q.push_back(8'h0A);
    end
  endfunction

  function automatic void queue_record();
    int          pick;
    int          n;
    logic [7:0]  len;
    logic [7:0]  kind;
    logic [15:0] ofs;
    pick = $urandom_range(0, 99);
    ofs  = ($urandom_range(0, 4) == 0) ? {12'hFFF, 4'($urandom_range(0, 15))}
                                       : 16'($urandom_range(0, 65535));
    if (!max_len_done && random_chars >= 300) begin
      // Longest record once: 63 words and three trailing bytes.
      max_len_done = 1'b1;
      push_header(8'hFF, ofs, KindData);
      push_payload(255);
      push_tail();
    end else if (pick < 55) begin
      n = $urandom_range(0, 9);
      if (n < 7)      len = 8'($urandom_range(1, 6) * 4);
      else if (n < 8) len = 8'($urandom_range(0, 3));   // too short for a word
      else            len = 8'($urandom_range(0, 40));
      push_header(len, ofs, KindData);
      push_payload(len);
      push_tail();
    end else if (pick < 70) begin
      // Extended address: the length field does not matter to the block.
      len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 8)) : 8'd2;
      push_header(len, 16'h0000, KindExtLin);
      if ($urandom_range(0, 2) == 0) begin
        push_byte(8'hFF);
        push_byte(8'hFF);
      end else begin
        push_payload(2);
      end
      push_payload(len > 8'd2 ? len - 2 : 0);
      push_tail();
    end else if (pick < 80) begin
      kind = 8'($urandom_range(0, 255));
      if (kind == KindData || kind == KindExtLin) kind = 8'h01;
      len = 8'($urandom_range(0, 8));
      push_header(len, ofs, kind);
      push_payload(len);
      push_tail();
    end else if (pick < 90) begin
      // Record cut short; the next colon may be read as a digit inside it.
      text_q.push_back(ColonCode);
      push_payload($urandom_range(1, 6));
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) text_q.push_back(CharW'($urandom_range(0, 255)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of characters with random gaps. The model is advanced in
  // the step the character is taken; its word reaches word_o only through the input and result registers.
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [CharW-1:0] c, input bit typed,
                           input stored_word_t typed_word);
    stored_word_t w;
    int           gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        char_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    if (decode_char(c, w)) pending_words.push_back(typed ? typed_word : w);
  endtask

  // Directed text: line noise at both code extremes, an extended address
  // record with a zero length that still loads the upper half, then a data
  // record whose word lands at the very top of memory.
  text_row_t directed_rows [32] = '{
    '{8'h00, 1'b0, '0, '0}, '{8'hFF, 1'b0, '0, '0},
    '{":", 1'b0, '0, '0}, '{"0", 1'b0, '0, '0}, '{"0", 1'b0, '0, '0},
    '{"0", 1'b0, '0, '0}, '{"0", 1'b0, '0, '0}, '{"0", 1'b0, '0, '0},
    '{"0", 1'b0, '0, '0},
    '{"0", 1'b0, '0, '0}, '{"4", 1'b0, '0, '0},
    '{"F", 1'b0, '0, '0}, '{"F", 1'b0, '0, '0}, '{"F", 1'b0, '0, '0},
    '{"F", 1'b0, '0, '0},
    '{":", 1'b0, '0, '0}, '{"0", 1'b0, '0, '0}, '{"4", 1'b0, '0, '0},
    '{"F", 1'b0, '0, '0}, '{"F", 1'b0, '0, '0}, '{"F", 1'b0, '0, '0},
    '{"C", 1'b0, '0, '0},
    '{"0", 1'b0, '0, '0}, '{"0", 1'b0, '0, '0},
    '{"1", 1'b0, '0, '0}, '{"2", 1'b0, '0, '0}, '{"3", 1'b0, '0, '0},
    '{"4", 1'b0, '0, '0},
    '{"5", 1'b0, '0, '0}, '{"6", 1'b0, '0, '0}, '{"7", 1'b0, '0, '0},
    '{"8", 1'b1, 32'hFFFF_FFFC, 32'h7856_3412}
  };

  initial begin
    char_bus.valid     <= 1'b0;
    char_bus.char_code <= '0;
    clear_decoder();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_char(directed_rows[i].ch, directed_rows[i].typed,
                {directed_rows[i].addr, directed_rows[i].data});

    // Ask for the long word-side stall while text keeps streaming in.
    hold_wanted = 1'b1;
    while (random_chars < TextTarget) begin
      queue_record();
      while (text_q.size() > 0) begin
        send_char(text_q.pop_front(), 1'b0, '0);
        random_chars++;
      end
    end
    char_bus.valid <= 1'b0;

    while (pending_words.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_intel_hex_word_loader OK");
    end else begin
      $display("tb_intel_hex_word_loader NOT OK");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a pattern picked anew whenever tick[5:0] is zero,
  // with one long hold-off so the loader fills and stalls the character side.
  // ---------------------------------------------------------------------------
  initial begin
    int          mode;
    logic [31:0] tick;
    mode = 0;
    tick = '0;
    word_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      tick++;
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        word_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      if (tick[5:0] == '0) mode = $urandom_range(0, 3);
      case (mode)
        0:       word_bus.ready <= 1'b1;
        1:       word_bus.ready <= (tick % 5) >= 2;
        2:       word_bus.ready <= 1'($urandom_range(0, 1));
        default: word_bus.ready <= tick[3];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Word checker and watchdog.
  // ---------------------------------------------------------------------------
  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= ReportLimit)
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
  endfunction

  always @(posedge clk) begin
    stored_word_t want;
    if (rst_n && word_bus.valid && word_bus.ready) begin
      if (pending_words.size() == 0) begin
        flag_mismatch("unexpected word at address", '0, word_bus.word_address);
      end else begin
        want = pending_words.pop_front();
        if (word_bus.word_address !== want.addr)
          flag_mismatch("word_address", want.addr, word_bus.word_address);
        if (word_bus.word_data !== want.data)
          flag_mismatch("word_data", want.data, word_bus.word_data);
      end
    end
  end

  // Count cycles in which nothing moves on either channel; give up at the limit.
  always @(posedge clk) begin
    if ((char_bus.valid && char_bus.ready) || (word_bus.valid && word_bus.ready)) begin
      idle_cycles = 0;
    end else if (rst_n) begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_intel_hex_word_loader NOT OK");
        $finish;
      end
    end
  end

endmodule

// ----- filelist.f -----
hw/rtl/ihex_pkg.sv
hw/rtl/ihex_char_if.sv
hw/rtl/ihex_word_if.sv
hw/rtl/ihex_in_reg.sv
hw/rtl/ihex_decoder.sv
hw/rtl/ihex_out_reg.sv
hw/rtl/intel_hex_word_loader.sv
sim/tb_intel_hex_word_loader.sv
